/* design/dpsm_pkg.sv */
// shared types, constants and helpers of the decoded picture slot manager
`default_nettype none

package dpsm_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   localparam int PIC_W   = 32;
   localparam int FLAG_W  = 4;
   localparam int FRAME_W = 16;
   localparam int ORDER_W = 32;
   localparam int AGE_W   = 32;
   localparam int SLOT_W  = 4;
   localparam int STAT_W  = 2;
   localparam int TYPE_W  = 3;

   // payload entry: picture, flags, frame, top order, bottom order from the lowest bit up
   localparam int PAY_W = PIC_W + FLAG_W + FRAME_W + 2 * ORDER_W;

   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 128;

   localparam logic [TYPE_W-1:0] REQ_START  = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_REF    = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_LOOKUP = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_FINISH = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ   = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_SLOT = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_IGNORED = 2'd2;

   localparam logic [PIC_W-1:0] NULL_PICTURE = '1;

   localparam int FLAG_TOP     = 0;
   localparam int FLAG_BOTTOM  = 1;
   localparam int FLAG_LONG    = 2;
   localparam int FLAG_INVALID = 3;

   typedef struct packed {
      logic valid;
      logic rsv;
      logic used;
   } mark_type;

   typedef struct packed {
      logic clear;
      logic cmp_vld;
   } scan_ctl_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] found_idx;
      logic             free;
      logic [IDX_W-1:0] free_idx;
      logic             best;
      logic [IDX_W-1:0] best_idx;
   } scan_res_type;

   function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, idx};
      return ext[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/decoded_picture_slot_manager_top.sv */
// top level of the decoded picture slot manager: sequencer, slot marks and result register
`default_nettype none

// Keeps SLOT_COUNT reference picture slots tagged by picture id. Start, reference,
// lookup and finish beats scan every slot once through the slot memories, one slot a
// cycle, then commit; the scan is serial because of the single read port of the slot
// memories. Read beats read the addressed slot, then commit. A new beat is accepted
// while a result still waits on rsp_. Results are committed only when the result
// register is free, so a stalled rsp_ side holds the block in its commit cycle. No
// clearing pass is needed after reset.
module decoded_picture_slot_manager_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // picture, top_field, bottom_field, long_term, invalid_mark, frame_number,
   // top_order, bottom_order, read_slot
   input  wire logic [dpsm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  wire logic [dpsm_pkg::TYPE_W-1:0]       req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // slot, hit, field_refs, entry_valid, entry_active, entry_long_term, entry_picture,
   // entry_frame, entry_top_order, entry_bottom_order, zero padding
   output logic      [dpsm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic      [dpsm_pkg::STAT_W-1:0]       rsp_tuser
);

   localparam int N     = dpsm_pkg::SLOT_COUNT;
   localparam int IDXW  = dpsm_pkg::IDX_W;
   localparam int CNTW  = dpsm_pkg::CNT_W;
   localparam int RSW   = IDXW + dpsm_pkg::SLOT_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_READ, ST_EXEC} state_type;

   state_type state_ff, state_in;

   logic [dpsm_pkg::TYPE_W-1:0]  type_ff;
   logic [dpsm_pkg::PIC_W-1:0]   pic_ff;
   logic [dpsm_pkg::FLAG_W-1:0]  flags_ff;
   logic [dpsm_pkg::FRAME_W-1:0] frame_ff;
   logic [dpsm_pkg::ORDER_W-1:0] top_ff;
   logic [dpsm_pkg::ORDER_W-1:0] bot_ff;
   logic [dpsm_pkg::SLOT_W-1:0]  rslot_ff;

   logic [CNTW-1:0] rd_idx_ff, rd_idx_in;
   logic            cmp_vld_ff, cmp_vld_in;
   logic [IDXW-1:0] cmp_idx_ff, cmp_idx_in;

   logic [N-1:0] valid_ff, valid_in;
   logic [N-1:0] rsv_ff, rsv_in;
   logic [N-1:0] used_ff, used_in;

   logic [dpsm_pkg::AGE_W-1:0] age_cnt_ff, age_cnt_in;
   logic [IDXW-1:0]            out_slot_ff, out_slot_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dpsm_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [dpsm_pkg::STAT_W-1:0]       rsp_stat_ff, rsp_stat_in;

   logic req_fire, exec_fire;

   logic                        ram_re, pay_we, age_we;
   logic [IDXW-1:0]             ram_addr, wr_idx;
   logic [dpsm_pkg::PAY_W-1:0]  pay_wdata, pay_rdata;
   logic [dpsm_pkg::AGE_W-1:0]  age_wdata, age_rdata;

   logic [RSW-1:0]  rs_ext;
   logic            rs_oor;
   logic [IDXW-1:0] read_idx, mark_idx;

   dpsm_pkg::mark_type     mark_sel;
   dpsm_pkg::scan_ctl_type scan_ctl;
   dpsm_pkg::scan_res_type scan_res;

   logic                        pic_null, alloc_ok;
   logic [IDXW-1:0]             alloc_idx;
   logic [dpsm_pkg::SLOT_W-1:0] o_slot;
   logic                        o_hit, o_valid, o_active, o_long;
   logic [1:0]                  o_fref;
   logic [dpsm_pkg::PIC_W-1:0]   o_pic;
   logic [dpsm_pkg::FRAME_W-1:0] o_frame;
   logic [dpsm_pkg::ORDER_W-1:0] o_top, o_bot;
   logic [dpsm_pkg::STAT_W-1:0]  o_stat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign exec_fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   assign rs_ext   = RSW'(rslot_ff);
   assign rs_oor   = (rs_ext >= RSW'(N));
   assign read_idx = rs_ext[IDXW-1:0];
   assign mark_idx = (state_ff == ST_SCAN) ? cmp_idx_ff : read_idx;

   assign mark_sel.valid = valid_ff[mark_idx];
   assign mark_sel.rsv   = rsv_ff[mark_idx];
   assign mark_sel.used  = used_ff[mark_idx];

   assign scan_ctl.clear   = req_fire;
   assign scan_ctl.cmp_vld = cmp_vld_ff;

   assign pic_null  = (pic_ff == dpsm_pkg::NULL_PICTURE);
   assign alloc_ok  = scan_res.free || scan_res.best;
   assign alloc_idx = scan_res.free ? scan_res.free_idx : scan_res.best_idx;

   assign pay_wdata = {bot_ff, top_ff, frame_ff, flags_ff, pic_ff};

   dpsm_ram #(
      .WIDTH (dpsm_pkg::PAY_W),
      .DEPTH (N)
   ) u_pay_ram (
      .clock (clock),
      .we    (pay_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (pay_wdata),
      .rdata (pay_rdata)
   );

   dpsm_ram #(
      .WIDTH (dpsm_pkg::AGE_W),
      .DEPTH (N)
   ) u_age_ram (
      .clock (clock),
      .we    (age_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (age_wdata),
      .rdata (age_rdata)
   );

   dpsm_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .idx       (cmp_idx_ff),
      .pic       (pic_ff),
      .entry_pic (pay_rdata[dpsm_pkg::PIC_W-1:0]),
      .entry_age (age_rdata),
      .mark      (mark_sel),
      .res       (scan_res)
   );

   // sequencing and memory port
   always_comb begin
      state_in   = state_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      ram_re     = 1'b0;
      ram_addr   = wr_idx;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rd_idx_in = '0;
               if (req_tuser == dpsm_pkg::REQ_READ) begin
                  state_in = ST_READ;
               end else if (req_tuser == dpsm_pkg::REQ_START ||
                            req_tuser == dpsm_pkg::REQ_REF ||
                            req_tuser == dpsm_pkg::REQ_LOOKUP ||
                            req_tuser == dpsm_pkg::REQ_FINISH) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_SCAN: begin
            ram_addr = rd_idx_ff[IDXW-1:0];
            if (rd_idx_ff == CNTW'(N)) begin
               state_in = ST_EXEC;
            end else begin
               ram_re     = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDXW-1:0];
               rd_idx_in  = rd_idx_ff + CNTW'(1);
            end
         end
         ST_READ: begin
            ram_addr = read_idx;
            ram_re   = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commit of one beat
   always_comb begin
      valid_in    = valid_ff;
      rsv_in      = rsv_ff;
      used_in     = used_ff;
      age_cnt_in  = age_cnt_ff;
      out_slot_in = out_slot_ff;
      pay_we      = 1'b0;
      age_we      = 1'b0;
      wr_idx      = '0;
      age_wdata   = age_cnt_ff;
      o_slot      = '0;
      o_hit       = 1'b0;
      o_fref      = '0;
      o_valid     = 1'b0;
      o_active    = 1'b0;
      o_long      = 1'b0;
      o_pic       = '0;
      o_frame     = '0;
      o_top       = '0;
      o_bot       = '0;
      o_stat      = dpsm_pkg::STATUS_OK;
      case (type_ff)
         dpsm_pkg::REQ_START: begin
            if (scan_res.found || alloc_ok) begin
               wr_idx      = scan_res.found ? scan_res.found_idx : alloc_idx;
               age_we      = exec_fire;
               age_wdata   = '0;
               valid_in[wr_idx] = 1'b0;
               rsv_in[wr_idx]   = 1'b1;
               out_slot_in = wr_idx;
               o_slot      = dpsm_pkg::slot_field(wr_idx);
               o_hit       = scan_res.found;
            end else begin
               o_stat = dpsm_pkg::STATUS_NO_SLOT;
            end
            age_cnt_in = age_cnt_ff + dpsm_pkg::AGE_W'(1);
            used_in    = '0;
         end
         dpsm_pkg::REQ_REF: begin
            if (pic_null) begin
               o_stat = dpsm_pkg::STATUS_IGNORED;
            end else if (scan_res.found) begin
               wr_idx          = scan_res.found_idx;
               age_we          = exec_fire;
               used_in[wr_idx] = 1'b1;
               o_slot          = dpsm_pkg::slot_field(wr_idx);
               o_hit           = 1'b1;
            end else if (alloc_ok) begin
               wr_idx           = alloc_idx;
               pay_we           = exec_fire;
               age_we           = exec_fire;
               valid_in[wr_idx] = 1'b1;
               rsv_in[wr_idx]   = 1'b0;
               used_in[wr_idx]  = !flags_ff[dpsm_pkg::FLAG_INVALID];
               o_slot           = dpsm_pkg::slot_field(wr_idx);
            end else begin
               o_stat = dpsm_pkg::STATUS_NO_SLOT;
            end
         end
         dpsm_pkg::REQ_LOOKUP: begin
            if (scan_res.found) begin
               o_slot = dpsm_pkg::slot_field(scan_res.found_idx);
               o_hit  = 1'b1;
               o_fref = {flags_ff[dpsm_pkg::FLAG_BOTTOM], flags_ff[dpsm_pkg::FLAG_TOP]};
            end else begin
               o_stat = dpsm_pkg::STATUS_NO_SLOT;
            end
         end
         dpsm_pkg::REQ_FINISH: begin
            if (pic_null) begin
               o_stat = dpsm_pkg::STATUS_IGNORED;
            end else if (scan_res.found) begin
               o_slot = dpsm_pkg::slot_field(scan_res.found_idx);
               o_hit  = 1'b1;
               o_stat = dpsm_pkg::STATUS_IGNORED;
            end else begin
               wr_idx           = out_slot_ff;
               pay_we           = exec_fire;
               age_we           = exec_fire;
               valid_in[wr_idx] = 1'b1;
               rsv_in[wr_idx]   = 1'b0;
               used_in[wr_idx]  = !flags_ff[dpsm_pkg::FLAG_INVALID];
               o_slot           = dpsm_pkg::slot_field(wr_idx);
            end
         end
         dpsm_pkg::REQ_READ: begin
            if (rs_oor) begin
               o_stat = dpsm_pkg::STATUS_IGNORED;
            end else begin
               o_slot = dpsm_pkg::slot_field(read_idx);
               if (mark_sel.valid) begin
                  o_valid  = 1'b1;
                  o_active = mark_sel.used;
                  o_long   = pay_rdata[dpsm_pkg::PIC_W + dpsm_pkg::FLAG_LONG];
                  {o_bot, o_top, o_frame} =
                     pay_rdata[dpsm_pkg::PAY_W-1:dpsm_pkg::PIC_W+dpsm_pkg::FLAG_W];
                  o_pic = pay_rdata[dpsm_pkg::PIC_W-1:0];
               end
            end
         end
         default: begin
            o_stat = dpsm_pkg::STATUS_IGNORED;
         end
      endcase
      if (!exec_fire) begin
         valid_in    = valid_ff;
         rsv_in      = rsv_ff;
         used_in     = used_ff;
         age_cnt_in  = age_cnt_ff;
         out_slot_in = out_slot_ff;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, o_bot, o_top, o_frame, o_pic, o_long, o_active, o_valid,
                         o_fref, o_hit, o_slot};
         rsp_stat_in  = o_stat;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         cmp_idx_ff   <= '0;
         valid_ff     <= '0;
         rsv_ff       <= '0;
         used_ff      <= '0;
         age_cnt_ff   <= '0;
         out_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_vld_ff   <= cmp_vld_in;
         cmp_idx_ff   <= cmp_idx_in;
         valid_ff     <= valid_in;
         rsv_ff       <= rsv_in;
         used_ff      <= used_in;
         age_cnt_ff   <= age_cnt_in;
         out_slot_ff  <= out_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
      if (req_fire) begin
         type_ff  <= req_tuser;
         pic_ff   <= req_tdata[31:0];
         flags_ff <= req_tdata[35:32];
         frame_ff <= req_tdata[51:36];
         top_ff   <= req_tdata[83:52];
         bot_ff   <= req_tdata[115:84];
         rslot_ff <= req_tdata[119:116];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

   // a slot is never both holding a picture and reserved
   a_valid_rsv_excl: assert property (@(posedge clock) disable iff (reset)
      (valid_ff & rsv_ff) == '0)
      else $error("slot both valid and reserved");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("beat accepted while busy");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EXEC))
      else $error("result raised outside commit");

   a_match_is_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && scan_res.found) |-> valid_ff[scan_res.found_idx])
      else $error("scan match on slot without picture");

endmodule

`default_nettype wire

/* design/dpsm_ram.sv */
// single-port synchronous ram with registered read data
`default_nettype none

module dpsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/dpsm_scan.sv */
// slot scan unit: first match, first free slot and oldest unused slot
`default_nettype none

module dpsm_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dpsm_pkg::scan_ctl_type        ctl,
   input  wire logic [dpsm_pkg::IDX_W-1:0]    idx,
   input  wire logic [dpsm_pkg::PIC_W-1:0]    pic,
   input  wire logic [dpsm_pkg::PIC_W-1:0]    entry_pic,
   input  wire logic [dpsm_pkg::AGE_W-1:0]    entry_age,
   input  wire dpsm_pkg::mark_type            mark,
   output dpsm_pkg::scan_res_type             res
);

   dpsm_pkg::scan_res_type          res_ff, res_in;
   logic [dpsm_pkg::AGE_W-1:0]      best_age_ff, best_age_in;

   always_comb begin
      res_in      = res_ff;
      best_age_in = best_age_ff;
      if (ctl.clear) begin
         res_in      = '0;
         best_age_in = '1;
      end else if (ctl.cmp_vld) begin
         if (!res_ff.found && mark.valid && entry_pic == pic) begin
            res_in.found     = 1'b1;
            res_in.found_idx = idx;
         end
         if (!res_ff.free && !mark.valid && !mark.rsv) begin
            res_in.free     = 1'b1;
            res_in.free_idx = idx;
         end
         if (!mark.used && entry_age < best_age_ff) begin
            res_in.best     = 1'b1;
            res_in.best_idx = idx;
            best_age_in     = entry_age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff      <= '0;
         best_age_ff <= '1;
      end else begin
         res_ff      <= res_in;
         best_age_ff <= best_age_in;
      end
   end

   assign res = res_ff;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// self-checking stream bench for the decoded picture slot manager with a slot table predictor
`timescale 1ns / 100ps

module testbench;

   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_START   = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int ITEM_TARGET  = 850;
   localparam int POOL_SIZE    = 24;
   localparam int SETTLE_WAIT  = 40;
   localparam logic [dpsm_pkg::TYPE_W-1:0] REQ_LAST_CODE = '1;

   typedef struct packed {
      logic [dpsm_pkg::TYPE_W-1:0]         kind;
      logic [dpsm_pkg::SLOT_W-1:0]         read_slot;
      logic signed [dpsm_pkg::ORDER_W-1:0] bottom_order;
      logic signed [dpsm_pkg::ORDER_W-1:0] top_order;
      logic [dpsm_pkg::FRAME_W-1:0]        frame;
      logic                                invalid;
      logic                                long_term;
      logic                                bottom;
      logic                                top;
      logic [dpsm_pkg::PIC_W-1:0]          picture;
   } dpb_cmd_type;

   typedef struct packed {
      logic [dpsm_pkg::STAT_W-1:0]         status;
      logic signed [dpsm_pkg::ORDER_W-1:0] bottom_order;
      logic signed [dpsm_pkg::ORDER_W-1:0] top_order;
      logic [dpsm_pkg::FRAME_W-1:0]        frame;
      logic [dpsm_pkg::PIC_W-1:0]          picture;
      logic                                long_term;
      logic                                active;
      logic                                valid;
      logic [1:0]                          field_refs;
      logic                                hit;
      logic [dpsm_pkg::SLOT_W-1:0]         slot;
   } dpb_reply_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dpsm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [dpsm_pkg::TYPE_W-1:0]     req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dpsm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [dpsm_pkg::STAT_W-1:0]     rsp_tuser;

   decoded_picture_slot_manager_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // predicted slot table
   logic [dpsm_pkg::PIC_W-1:0]   tab_picture [dpsm_pkg::SLOT_COUNT];
   logic [dpsm_pkg::FLAG_W-1:0]  tab_flags   [dpsm_pkg::SLOT_COUNT];
   logic [dpsm_pkg::FRAME_W-1:0] tab_frame   [dpsm_pkg::SLOT_COUNT];
   logic [dpsm_pkg::ORDER_W-1:0] tab_top     [dpsm_pkg::SLOT_COUNT];
   logic [dpsm_pkg::ORDER_W-1:0] tab_bottom  [dpsm_pkg::SLOT_COUNT];
   logic [dpsm_pkg::AGE_W-1:0]   tab_age     [dpsm_pkg::SLOT_COUNT];
   dpsm_pkg::mark_type           tab_mark    [dpsm_pkg::SLOT_COUNT];
   logic [dpsm_pkg::AGE_W-1:0]   age_now;
   int                           cur_slot;

   dpb_cmd_type   dpb_cmds [$];
   dpb_reply_type dpb_expected [$];
   logic [dpsm_pkg::PIC_W-1:0] pic_pool [POOL_SIZE];

   dpb_cmd_type   tx_cmd;
   dpb_reply_type want_reply;
   dpb_reply_type got_reply;
   logic       req_fired   = 1'b0;
   int         tx_gap      = 0;
   int         tx_count    = 0;
   int         rx_stall    = 0;
   int         rx_cycles   = 0;
   int         idle_cycles = 0;
   int         mismatches  = 0;

   function automatic int held_slot(input logic [dpsm_pkg::PIC_W-1:0] pic);
      int i;
      for (i = 0; i < dpsm_pkg::SLOT_COUNT; i++)
         if (tab_mark[i].valid && tab_picture[i] == pic) return i;
      return -1;
   endfunction

   // free slot first, else the oldest slot not used by the current picture
   function automatic int victim_slot();
      logic [dpsm_pkg::AGE_W-1:0] best_age;
      int best;
      int i;
      best_age = '1;
      best = -1;
      for (i = 0; i < dpsm_pkg::SLOT_COUNT; i++)
         if (!tab_mark[i].valid && !tab_mark[i].rsv) return i;
      for (i = 0; i < dpsm_pkg::SLOT_COUNT; i++) begin
         if (!tab_mark[i].used && tab_age[i] < best_age) begin
            best_age = tab_age[i];
            best = i;
         end
      end
      return best;
   endfunction

   function automatic void store_picture(input int s, input dpb_cmd_type c);
      tab_picture[s] = c.picture;
      tab_flags[s]   = {c.invalid, c.long_term, c.bottom, c.top};
      tab_frame[s]   = c.frame;
      tab_top[s]     = c.top_order;
      tab_bottom[s]  = c.bottom_order;
      tab_age[s]     = age_now;
      tab_mark[s]    = {1'b1, 1'b0, ~c.invalid};
   endfunction

   function automatic dpb_reply_type slot_manager_reply(input dpb_cmd_type c);
      dpb_reply_type r;
      int s;
      int i;
      r = '0;
      case (c.kind)
         dpsm_pkg::REQ_START: begin
            s = held_slot(c.picture);
            if (s >= 0) r.hit = 1'b1;
            else s = victim_slot();
            if (s >= 0) begin
               tab_picture[s] = '0;
               tab_flags[s]   = '0;
               tab_frame[s]   = '0;
               tab_top[s]     = '0;
               tab_bottom[s]  = '0;
               tab_age[s]     = '0;
               tab_mark[s]    = {1'b0, 1'b1, 1'b0};
               cur_slot       = s;
               r.slot         = dpsm_pkg::SLOT_W'(s);
            end else begin
               r.status = dpsm_pkg::STATUS_NO_SLOT;
            end
            age_now = age_now + dpsm_pkg::AGE_W'(1);
            for (i = 0; i < dpsm_pkg::SLOT_COUNT; i++) tab_mark[i].used = 1'b0;
         end
         dpsm_pkg::REQ_REF: begin
            if (c.picture == dpsm_pkg::NULL_PICTURE) begin
               r.status = dpsm_pkg::STATUS_IGNORED;
            end else begin
               s = held_slot(c.picture);
               if (s >= 0) begin
                  tab_age[s]       = age_now;
                  tab_mark[s].used = 1'b1;
                  r.slot           = dpsm_pkg::SLOT_W'(s);
                  r.hit            = 1'b1;
               end else begin
                  s = victim_slot();
                  if (s < 0) begin
                     r.status = dpsm_pkg::STATUS_NO_SLOT;
                  end else begin
                     store_picture(s, c);
                     r.slot = dpsm_pkg::SLOT_W'(s);
                  end
               end
            end
         end
         dpsm_pkg::REQ_LOOKUP: begin
            s = held_slot(c.picture);
            if (s < 0) begin
               r.status = dpsm_pkg::STATUS_NO_SLOT;
            end else begin
               r.slot       = dpsm_pkg::SLOT_W'(s);
               r.hit        = 1'b1;
               r.field_refs = {c.bottom, c.top};
            end
         end
         dpsm_pkg::REQ_FINISH: begin
            if (c.picture == dpsm_pkg::NULL_PICTURE) begin
               r.status = dpsm_pkg::STATUS_IGNORED;
            end else begin
               s = held_slot(c.picture);
               if (s >= 0) begin
                  r.slot   = dpsm_pkg::SLOT_W'(s);
                  r.hit    = 1'b1;
                  r.status = dpsm_pkg::STATUS_IGNORED;
               end else begin
                  s = cur_slot % dpsm_pkg::SLOT_COUNT;
                  store_picture(s, c);
                  r.slot = dpsm_pkg::SLOT_W'(s);
               end
            end
         end
         dpsm_pkg::REQ_READ: begin
            s = int'(c.read_slot);
            if (s >= dpsm_pkg::SLOT_COUNT) begin
               r.status = dpsm_pkg::STATUS_IGNORED;
            end else begin
               r.slot = dpsm_pkg::SLOT_W'(s);
               if (tab_mark[s].valid) begin
                  r.valid        = 1'b1;
                  r.active       = tab_mark[s].used;
                  r.long_term    = tab_flags[s][dpsm_pkg::FLAG_LONG];
                  r.picture      = tab_picture[s];
                  r.frame        = tab_frame[s];
                  r.top_order    = tab_top[s];
                  r.bottom_order = tab_bottom[s];
               end
            end
         end
         default: r.status = dpsm_pkg::STATUS_IGNORED;
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   function automatic logic [dpsm_pkg::PIC_W-1:0] fresh_id();
      logic [dpsm_pkg::PIC_W-1:0] id;
      id = $urandom;
      return (id == dpsm_pkg::NULL_PICTURE) ? '0 : id;
   endfunction

   function automatic logic [dpsm_pkg::PIC_W-1:0] pool_pick();
      return pic_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   task automatic push_cmd(input logic [dpsm_pkg::TYPE_W-1:0] kind,
                           input logic [dpsm_pkg::PIC_W-1:0] pic,
                           input logic [dpsm_pkg::FLAG_W-1:0] flags,
                           input logic [dpsm_pkg::FRAME_W-1:0] frame,
                           input logic [dpsm_pkg::ORDER_W-1:0] top_order,
                           input logic [dpsm_pkg::ORDER_W-1:0] bottom_order,
                           input logic [dpsm_pkg::SLOT_W-1:0] read_slot);
      dpb_cmd_type c;
      c.kind         = kind;
      c.picture      = pic;
      c.top          = flags[dpsm_pkg::FLAG_TOP];
      c.bottom       = flags[dpsm_pkg::FLAG_BOTTOM];
      c.long_term    = flags[dpsm_pkg::FLAG_LONG];
      c.invalid      = flags[dpsm_pkg::FLAG_INVALID];
      c.frame        = frame;
      c.top_order    = top_order;
      c.bottom_order = bottom_order;
      c.read_slot    = read_slot;
      dpb_cmds.insert(dpb_cmds.size(), c);
   endtask

   task automatic push_random(input logic [dpsm_pkg::TYPE_W-1:0] kind,
                              input logic [dpsm_pkg::PIC_W-1:0] pic);
      push_cmd(kind, pic, dpsm_pkg::FLAG_W'($urandom), dpsm_pkg::FRAME_W'($urandom),
               $urandom, $urandom, dpsm_pkg::SLOT_W'($urandom));
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      int i;
      int k;
      int n;
      int roll;
      int pick;
      logic [dpsm_pkg::PIC_W-1:0]  cur;
      logic [dpsm_pkg::FLAG_W-1:0] fl;
      for (i = 0; i < dpsm_pkg::SLOT_COUNT; i++) begin
         tab_picture[i] = '0;
         tab_flags[i]   = '0;
         tab_frame[i]   = '0;
         tab_top[i]     = '0;
         tab_bottom[i]  = '0;
         tab_age[i]     = '0;
         tab_mark[i]    = '0;
      end
      age_now  = '0;
      cur_slot = 0;
      for (i = 0; i < POOL_SIZE; i++) pic_pool[i] = fresh_id();
      pic_pool[0] = '0;
      pic_pool[1] = dpsm_pkg::NULL_PICTURE - 1'b1;

      // directed opening
      push_cmd(dpsm_pkg::REQ_READ, '0, '0, '0, '0, '0, '1);
      push_random(dpsm_pkg::REQ_FINISH, dpsm_pkg::NULL_PICTURE);
      // finish with no start yet lands in slot 0
      push_cmd(dpsm_pkg::REQ_FINISH, '0, '1, '1, 32'h7fff_ffff, 32'h8000_0000, '0);
      push_random(dpsm_pkg::REQ_REF, dpsm_pkg::NULL_PICTURE);
      push_random(dpsm_pkg::REQ_LOOKUP, dpsm_pkg::NULL_PICTURE - 1'b1);
      push_cmd(dpsm_pkg::REQ_LOOKUP, '0, 4'b0011, '0, '0, '0, '0);
      push_random(dpsm_pkg::REQ_START, dpsm_pkg::NULL_PICTURE - 1'b1);
      push_cmd(dpsm_pkg::REQ_REF, '0, '0, '0, '0, '0, '0);
      // fill the table, the reserved slot goes too, the last one finds no slot
      for (k = 0; k < dpsm_pkg::SLOT_COUNT; k++) begin
         fl = dpsm_pkg::FLAG_W'($urandom);
         fl[dpsm_pkg::FLAG_INVALID] = 1'b0;
         push_cmd(dpsm_pkg::REQ_REF, 32'h1000_0000 + k, fl, dpsm_pkg::FRAME_W'($urandom),
                  $urandom, $urandom, dpsm_pkg::SLOT_W'($urandom));
      end
      push_random(dpsm_pkg::REQ_START, 32'h2000_0000);
      push_random(dpsm_pkg::REQ_FINISH, dpsm_pkg::NULL_PICTURE - 1'b1);
      push_random(dpsm_pkg::REQ_FINISH, '0);
      push_random(dpsm_pkg::REQ_START, '0);
      push_random(dpsm_pkg::REQ_READ + 1'b1, '0);
      push_random(REQ_LAST_CODE, '0);

      while (dpb_cmds.size() < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            // flood of new references to run out of slots
            push_random(dpsm_pkg::REQ_START, pool_pick());
            n = $urandom_range(14, 20);
            for (k = 0; k < n; k++) begin
               fl = dpsm_pkg::FLAG_W'($urandom);
               fl[dpsm_pkg::FLAG_INVALID] = ($urandom_range(0, 7) == 0);
               push_cmd(dpsm_pkg::REQ_REF, fresh_id(), fl, dpsm_pkg::FRAME_W'($urandom),
                        $urandom, $urandom, dpsm_pkg::SLOT_W'($urandom));
            end
            push_random(dpsm_pkg::REQ_FINISH, pool_pick());
         end else if (roll < 16) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               pick = $urandom_range(0, 3);
               push_random(dpsm_pkg::TYPE_W'($urandom),
                           (pick == 0) ? dpsm_pkg::NULL_PICTURE :
                           (pick == 1) ? fresh_id() : pool_pick());
            end
         end else begin
            cur = ($urandom_range(0, 9) == 0) ? fresh_id() : pool_pick();
            push_random(dpsm_pkg::REQ_START, cur);
            n = $urandom_range(2, 18);
            for (k = 0; k < n; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 45) push_random(dpsm_pkg::REQ_REF, pool_pick());
               else if (pick < 50) push_random(dpsm_pkg::REQ_REF, fresh_id());
               else if (pick < 70) push_random(dpsm_pkg::REQ_LOOKUP, pool_pick());
               else if (pick < 75) push_random(dpsm_pkg::REQ_LOOKUP, fresh_id());
               else if (pick < 92) push_random(dpsm_pkg::REQ_READ, '0);
               else if (pick < 96) push_random(dpsm_pkg::REQ_REF, dpsm_pkg::NULL_PICTURE);
               else push_random(dpsm_pkg::REQ_FINISH, pool_pick());
            end
            pick = $urandom_range(0, 9);
            if (pick < 8) push_random(dpsm_pkg::REQ_FINISH, cur);
            else if (pick == 8) push_random(dpsm_pkg::REQ_FINISH, dpsm_pkg::NULL_PICTURE);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (dpb_cmds.size() != 0 || req_tvalid || dpb_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (dpb_cmds.size() > 0) begin
            tx_cmd = dpb_cmds.pop_front();
            req_tdata  <= tx_cmd[dpsm_pkg::REQ_DATA_W-1:0];
            req_tuser  <= tx_cmd.kind;
            req_tvalid <= 1'b1;
            tx_count++;
            tx_gap = ((tx_count % 160) < 40) ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver, one long hold-off to back the block up, then random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles == HOLD_START) rx_stall = HOLD_CYCLES;
         else if (rx_stall > 0) rx_stall--;
         else if ((rx_cycles % 1500) >= 300) rx_stall = pick_gap();
         rsp_tready <= (rx_stall == 0);
      end
   end

   // beat monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (dpb_expected.size() == 0) begin
               $error("result beat with no request outstanding");
               mismatches++;
            end else begin
               want_reply = dpb_expected.pop_front();
               got_reply  = dpb_reply_type'({rsp_tuser,
                  rsp_tdata[$bits(dpb_reply_type)-dpsm_pkg::STAT_W-1:0]});
               check_field("slot", 32'(want_reply.slot), 32'(got_reply.slot));
               check_field("hit", 32'(want_reply.hit), 32'(got_reply.hit));
               check_field("status", 32'(want_reply.status), 32'(got_reply.status));
               check_field("field_refs", 32'(want_reply.field_refs),
                           32'(got_reply.field_refs));
               check_field("entry_valid", 32'(want_reply.valid), 32'(got_reply.valid));
               check_field("entry_active", 32'(want_reply.active), 32'(got_reply.active));
               check_field("entry_long_term", 32'(want_reply.long_term),
                           32'(got_reply.long_term));
               check_field("entry_picture", want_reply.picture, got_reply.picture);
               check_field("entry_frame", 32'(want_reply.frame), 32'(got_reply.frame));
               check_field("entry_top_order", want_reply.top_order, got_reply.top_order);
               check_field("entry_bottom_order", want_reply.bottom_order,
                           got_reply.bottom_order);
            end
         end
         if (req_tvalid && req_tready)
            dpb_expected.insert(dpb_expected.size(),
               slot_manager_reply(dpb_cmd_type'({req_tuser, req_tdata})));
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
